[sv/nconv_pkg.sv]
`default_nettype none
package nconv_pkg;

    typedef enum logic [3:0] {
        OP_I2L = 4'd0,
        OP_I2F = 4'd1,
        OP_I2D = 4'd2,
        OP_L2I = 4'd3,
        OP_L2F = 4'd4,
        OP_L2D = 4'd5,
        OP_F2I = 4'd6,
        OP_F2L = 4'd7,
        OP_F2D = 4'd8,
        OP_D2I = 4'd9,
        OP_D2L = 4'd10,
        OP_D2F = 4'd11,
        OP_I2B = 4'd12,
        OP_I2S = 4'd13,
        OP_I2C = 4'd14,
        OP_BAD = 4'd15
    } op_t;

    localparam int OP_W  = 4;
    localparam int VAL_W = 64;

    // stage-1 to stage-2 record
    typedef struct packed {
        logic [3:0]  op;
        logic        neg;
        logic [63:0] mag;
        logic [6:0]  lz;
        logic [63:0] raw;
    } s1_t;

    // stage-2 to stage-3 record
    typedef struct packed {
        logic [3:0]  op;
        logic        neg;
        logic [63:0] norm;
        logic [6:0]  lz;
        logic [63:0] raw;
        logic [63:0] fix;
        logic        fix_done;
    } s2_t;

    typedef struct packed {
        logic [63:0] value;
        logic        wide;
    } res_t;

endpackage
`default_nettype wire

[sv/nconv_if.sv]
`default_nettype none
interface nconv_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [63:0] operand_value;
    modport source (output valid, output op, output operand_value, input ready);
    modport sink (input valid, input op, input operand_value, output ready);
endinterface

interface nconv_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic        result_wide;
    modport source (output valid, output result_value, output result_wide, input ready);
    modport sink (input valid, input result_value, input result_wide, output ready);
endinterface
`default_nettype wire

[sv/nconv_front.sv]
`default_nettype none
// stage 1: operand magnitude and leading-zero count
module nconv_front (
    input  wire logic [3:0]      op,
    input  wire logic [63:0]     operand_value,
    output nconv_pkg::s1_t       s1
);
    import nconv_pkg::*;

    logic [63:0] w;
    logic [63:0] src;
    logic        neg;
    logic        lng;

    always_comb
    begin
        w   = {32'd0, operand_value[31:0]};
        lng = (op == OP_L2F) || (op == OP_L2D);
        if (lng)
        begin
            neg = operand_value[63];
            src = neg ? (64'd0 - operand_value) : operand_value;
        end
        else
        begin
            neg = w[31];
            src = neg ? {32'd0, 32'd0 - w[31:0]} : w;
        end
        s1.op  = op;
        s1.neg = neg;
        s1.mag = src;
        s1.raw = operand_value;
        s1.lz  = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (src[i])
            begin
                s1.lz = 7'(63 - i);
            end
        end
    end
endmodule
`default_nettype wire

[sv/nconv_mid.sv]
`default_nettype none
// stage 2: normalize shift and the non-rounding conversions
module nconv_mid (
    input  wire nconv_pkg::s1_t  s1,
    output nconv_pkg::s2_t       s2
);
    import nconv_pkg::*;

    logic [31:0]  w;
    logic [10:0]  ex;
    logic [51:0]  fr;
    logic         sg;
    logic         dbl;
    logic         to64;
    logic [10:0]  bias;
    logic [10:0]  emax;
    logic [52:0]  mant;
    logic [6:0]   e;
    logic [116:0] shf;
    logic [63:0]  mag;
    logic [63:0]  sat;
    logic [63:0]  fi;
    logic [4:0]   p;
    logic [22:0]  ff;

    always_comb
    begin
        w    = s1.raw[31:0];
        dbl  = (s1.op == OP_D2I) || (s1.op == OP_D2L);
        to64 = (s1.op == OP_F2L) || (s1.op == OP_D2L);
        if (dbl)
        begin
            sg = s1.raw[63]; ex = s1.raw[62:52]; fr = s1.raw[51:0];
            bias = 11'd1023; emax = 11'h7ff; mant = {1'b1, fr};
        end
        else
        begin
            sg = w[31]; ex = {3'd0, w[30:23]}; fr = {w[22:0], 29'd0};
            bias = 11'd127; emax = 11'hff; mant = {1'b1, fr};
        end
        sat = to64 ? (sg ? 64'h8000000000000000 : 64'h7fffffffffffffff)
                   : (sg ? 64'h0000000080000000 : 64'h000000007fffffff);
        e   = (ex >= bias) ? 7'((ex - bias) > 11'd127 ? 11'd127 : (ex - bias)) : 7'd0;
        shf = {64'd0, mant} << e;
        mag = shf[115:52];
        if (ex == emax)
            fi = (fr != 52'd0) ? 64'd0 : sat;
        else if (ex < bias)
            fi = 64'd0;
        else if (e >= (to64 ? 7'd63 : 7'd31))
            fi = sat;
        else
        begin
            fi = sg ? (64'd0 - mag) : mag;
            if (!to64)
                fi = {32'd0, fi[31:0]};
        end

        // float to double
        ff = w[22:0];
        p = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (ff[i])
                p = 5'(i);
        end

        s2.op   = s1.op;
        s2.neg  = s1.neg;
        s2.lz   = s1.lz;
        s2.raw  = s1.raw;
        s2.norm = (s1.lz == 7'd64) ? 64'd0 : (s1.mag << s1.lz[5:0]);
        s2.fix_done = 1'b1;
        case (op_t'(s1.op))
            OP_I2L: s2.fix = {{32{w[31]}}, w};
            OP_L2I: s2.fix = {32'd0, w};
            OP_F2I, OP_F2L, OP_D2I, OP_D2L: s2.fix = fi;
            OP_F2D:
            begin
                // nan keeps its payload with the quiet bit forced
                if (w[30:23] == 8'hff)
                    s2.fix = (ff != 23'd0) ? {w[31], 11'h7ff, 1'b1, ff[21:0], 29'd0}
                                           : {w[31], 11'h7ff, 52'd0};
                else if (w[30:23] == 8'd0)
                begin
                    if (ff == 23'd0)
                        s2.fix = {w[31], 63'd0};
                    else
                        s2.fix = {w[31], 11'(p + 5'd0) + 11'd874,
                                  52'({29'd0, ff} << (6'd52 - 6'(p)))};
                end
                else
                    s2.fix = {w[31], {3'd0, w[30:23]} + 11'd896, ff, 29'd0};
            end
            OP_I2B: s2.fix = {32'd0, {24{w[7]}}, w[7:0]};
            OP_I2S: s2.fix = {32'd0, {16{w[15]}}, w[15:0]};
            OP_I2C: s2.fix = {48'd0, w[15:0]};
            OP_I2F, OP_I2D, OP_L2F, OP_L2D, OP_D2F:
            begin
                s2.fix = 64'd0;
                s2.fix_done = 1'b0;
            end
            default: s2.fix = 64'd0;
        endcase
    end
endmodule
`default_nettype wire

[sv/nconv_round.sv]
`default_nettype none
// stage 3: rounding and packing of float results
module nconv_round (
    input  wire nconv_pkg::s2_t  s2,
    output nconv_pkg::res_t      res
);
    import nconv_pkg::*;

    logic [6:0]  pos;
    logic [24:0] m32;
    logic [53:0] m64;
    logic        g32, s32, g64, s64;
    logic [63:0] f32;
    logic [63:0] f64;
    logic [10:0] dex;
    logic [51:0] dfr;
    logic        dsg;
    logic [52:0] dm;
    logic [11:0] fe;
    logic [11:0] sh;
    logic [83:0] wide_m;
    logic [54:0] q;
    logic        rb, st;
    logic [24:0] dmant;
    logic [31:0] df;

    always_comb
    begin
        pos = 7'd63 - s2.lz;
        // int to float: norm has leading one at bit 63
        m32 = {1'b0, s2.norm[63:40]};
        g32 = s2.norm[39];
        s32 = |s2.norm[38:0];
        if (g32 && (s32 || m32[0]))
            m32 = m32 + 25'd1;
        f32 = {32'd0, s2.neg, 31'((32'd126 + 32'(pos)) << 23) + 31'(m32)};
        m64 = {1'b0, s2.norm[63:11]};
        g64 = s2.norm[10];
        s64 = |s2.norm[9:0];
        if (g64 && (s64 || m64[0]))
            m64 = m64 + 54'd1;
        f64 = {s2.neg, 63'((64'd1022 + 64'(pos)) << 52) + 63'(m64)};
        if (s2.lz == 7'd64)
        begin
            f32 = 64'd0;
            f64 = 64'd0;
        end

        // double to float
        dsg = s2.raw[63];
        dex = s2.raw[62:52];
        dfr = s2.raw[51:0];
        dm  = {1'b1, dfr};
        fe  = {1'b0, dex} - 12'd896;
        if (dex >= 11'd897)
            sh = 12'd29;
        else
            sh = 12'd926 - {1'b0, dex};
        wide_m = {dm, 31'd0} >> sh;
        q  = {2'b00, wide_m[83:31]};
        rb = wide_m[30];
        st = |wide_m[29:0];
        if (sh > 12'd83)
        begin
            q = 55'd0; rb = 1'b0; st = 1'b0;
        end
        if (rb && (st || q[0]))
            q = q + 55'd1;
        // rounding carry may reach bit 24 and bump the exponent
        dmant = q[24:0];
        if (dex == 11'h7ff)
            df = (dfr != 52'd0) ? {dsg, 8'hff, 1'b1, dfr[50:29]} : {dsg, 8'hff, 23'd0};
        else if (dex == 11'd0)
            df = {dsg, 31'd0};
        else if (dex >= 11'd1151)
            df = {dsg, 8'hff, 23'd0};
        else if (dex >= 11'd897)
            df = {dsg, 31'(({19'd0, fe} - 31'd1) << 23) + 31'(dmant)};
        else
            df = {dsg, 31'(dmant)};

        res.wide = 1'b0;
        case (op_t'(s2.op))
            OP_I2F, OP_L2F: res.value = f32;
            OP_I2D, OP_L2D: res.value = f64;
            OP_D2F:         res.value = {32'd0, df};
            default:        res.value = s2.fix_done ? s2.fix : 64'd0;
        endcase
        case (op_t'(s2.op))
            OP_I2L, OP_I2D, OP_L2D, OP_F2L, OP_F2D, OP_D2L: res.wide = 1'b1;
            default: res.wide = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

[sv/jvm_numeric_conversion_unit_core.sv]
`default_nettype none
// pipeline: three register stages (s1_reg, s2_reg, r_reg), the last one drives the
// output channel
// throughput: one conversion per cycle, stalls propagate back through the stage valids
// each stage advances when its successor is empty or advancing
// reset: asynchronous active-low rst_n empties all stages; the data registers are not reset
module jvm_numeric_conversion_unit_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    nconv_in_if.sink   in_ch,
    nconv_out_if.source out_ch
);
    import nconv_pkg::*;

    s1_t  s1_c, s1_reg;
    s2_t  s2_c, s2_reg;
    res_t r_c, r_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic a3, a2, a1;

    assign a3 = !v3_reg || out_ch.ready;
    assign a2 = !v2_reg || a3;
    assign a1 = !v1_reg || a2;
    assign in_ch.ready = a1;

    nconv_front u_front (.op(in_ch.op), .operand_value(in_ch.operand_value), .s1(s1_c));
    nconv_mid   u_mid   (.s1(s1_reg), .s2(s2_c));
    nconv_round u_round (.s2(s2_reg), .res(r_c));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (a1) v1_reg <= in_ch.valid;
            if (a2) v2_reg <= v1_reg;
            if (a3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a1) s1_reg <= s1_c;
        if (a2) s2_reg <= s2_c;
        if (a3) r_reg  <= r_c;
    end

    assign out_ch.valid        = v3_reg;
    assign out_ch.result_value = r_reg.value;
    assign out_ch.result_wide  = r_reg.wide;
endmodule
`default_nettype wire
